// ----- rtl/mas_pkg.sv -----
// shared types and constants of the multihart memory access stage
// depends on nothing; imported by mas_ctrl, mas_dp and the top module
package mas_pkg;

  // load width codes (risc-v funct3)
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  // store sizes, low two bits of funct3
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // one held instruction
  typedef struct packed {
    logic [4:0]  rd;
    logic        no_dest;
    logic        is_load;
    logic        is_write;
    logic [2:0]  width_code;
    logic        is_ret;
    logic [15:0] address;
    logic [31:0] value;
  } entry_t;

  // one input beat as seen by the datapath
  typedef struct packed {
    logic       in_valid;
    logic [1:0] hart;
    entry_t     ent;
    logic [3:0] wb_full_mask;
  } in_item_t;

  // one result beat
  typedef struct packed {
    logic        out_valid;
    logic [1:0]  hart;
    logic [4:0]  rd;
    logic        no_dest;
    logic        is_ret;
    logic [31:0] value;
    logic [3:0]  slot_full_mask;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

  // datapath to controller: a hart would be served if the beat offered now were captured
  typedef struct packed {
    logic serve;
  } status_t;

endpackage

// ----- rtl/mas_channels.sv -----
// valid/ready channel interfaces for input and result beats
// no dependencies
interface mas_in_if;
  logic        valid;
  logic        ready;
  logic        in_valid;
  logic [1:0]  in_hart;
  logic [4:0]  in_rd;
  logic        in_no_dest;
  logic        in_is_load;
  logic        in_is_write;
  logic [2:0]  in_width_code;
  logic        in_is_ret;
  logic [15:0] in_address;
  logic [31:0] in_value;
  logic [3:0]  wb_full_mask;

  modport source (
    output valid, in_valid, in_hart, in_rd, in_no_dest, in_is_load, in_is_write,
           in_width_code, in_is_ret, in_address, in_value, wb_full_mask,
    input  ready
  );
  modport sink (
    input  valid, in_valid, in_hart, in_rd, in_no_dest, in_is_load, in_is_write,
           in_width_code, in_is_ret, in_address, in_value, wb_full_mask,
    output ready
  );
endinterface

interface mas_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [1:0]  out_hart;
  logic [4:0]  out_rd;
  logic        out_no_dest;
  logic        out_is_ret;
  logic [31:0] out_value;
  logic [3:0]  slot_full_mask;

  modport source (
    output valid, out_valid, out_hart, out_rd, out_no_dest, out_is_ret, out_value,
           slot_full_mask,
    input  ready
  );
  modport sink (
    input  valid, out_valid, out_hart, out_rd, out_no_dest, out_is_ret, out_value,
           slot_full_mask,
    output ready
  );
endinterface

// ----- rtl/mas_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module mas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/mas_ctrl.sv -----
// sequencer of the memory access stage: one item at a time
// depends on mas_pkg (cmd_t, status_t)
module mas_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_beat_valid,
  output logic             in_beat_ready,
  output logic             out_beat_valid,
  input  logic             out_beat_ready,
  output mas_pkg::cmd_t    cmd,
  input  mas_pkg::status_t status
);
  import mas_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE, S_READ, S_EXEC, S_OUT
  } state_t;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_beat_valid) begin
            state_r <= status.serve ? S_READ : S_EXEC;
          end
        end
        S_READ: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_beat_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_beat_ready  = rst_n && (state_r == S_IDLE);
  assign out_beat_valid = (state_r == S_OUT);

  always_comb begin
    cmd         = '0;
    cmd.capture = in_beat_ready && in_beat_valid;
    cmd.exec    = (state_r == S_EXEC);
  end
endmodule

// ----- rtl/mas_dp.sv -----
// datapath: held slots, hart pick, bank remainder, banked memory access
// depends on mas_pkg and mas_ram
module mas_dp #(
  parameter int NUM_HARTS      = 4,
  parameter int LOG_BANK_WORDS = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mas_pkg::cmd_t       cmd,
  output mas_pkg::status_t    status,
  input  mas_pkg::in_item_t   in_item,
  output mas_pkg::out_item_t  out_item
);
  import mas_pkg::*;

  localparam int HW   = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
  localparam int HI_W = (LOG_BANK_WORDS < 13) ? (14 - LOG_BANK_WORDS) : 1;
  localparam int AW   = HW + LOG_BANK_WORDS;

  entry_t               entries_r [NUM_HARTS];
  logic [HW-1:0]        bank_r    [NUM_HARTS];
  logic [NUM_HARTS-1:0] full_r;
  logic                 serve_r;
  logic [HW-1:0]        sel_r;
  out_item_t            out_r;

  logic [HW-1:0]        hart_red;
  logic [7:0]           wb8;
  logic [NUM_HARTS-1:0] wb_ext;
  logic                 pick_found;
  logic [HW-1:0]        pick_idx;
  logic                 serve_now;
  logic [HW-1:0]        sel_now;
  logic [NUM_HARTS-1:0] full_nxt;
  logic [HI_W-1:0]      hi_bits;
  logic [HW-1:0]        rem_acc;
  logic [HW:0]          rem_t;
  logic [HW:0]          bank_t;
  logic [HW-1:0]        bank_now;
  logic [7:0]           full8;
  out_item_t            out_nxt;

  entry_t        cur;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_rdata;
  logic [31:0]   mem_wdata;
  logic          mem_we;
  logic [7:0]    ld_byte;
  logic [15:0]   ld_half;
  logic [31:0]   ld_val;
  logic [3:0]    st_be;
  logic [31:0]   st_lanes;

  // hart number reduced to the configured hart count
  always_comb begin
    case (in_item.hart)
      2'd0:    hart_red = HW'(0 % NUM_HARTS);
      2'd1:    hart_red = HW'(1 % NUM_HARTS);
      2'd2:    hart_red = HW'(2 % NUM_HARTS);
      2'd3:    hart_red = HW'(3 % NUM_HARTS);
      default: hart_red = '0;
    endcase
  end

  // writeback bits above hart 3 read as free
  assign wb8    = {4'b0000, in_item.wb_full_mask};
  assign wb_ext = wb8[NUM_HARTS-1:0];

  // lowest held hart whose writeback slot is free
  always_comb begin
    pick_found = 1'b0;
    pick_idx   = '0;
    for (int h = NUM_HARTS - 1; h >= 0; h--) begin
      if (full_r[h] && !wb_ext[h]) begin
        pick_found = 1'b1;
        pick_idx   = HW'(h);
      end
    end
  end

  always_comb begin
    serve_now = pick_found || (in_item.in_valid && !wb_ext[hart_red]);
    sel_now   = pick_found ? pick_idx : hart_red;
    full_nxt  = full_r;
    if (in_item.in_valid) begin
      full_nxt[hart_red] = 1'b1;
    end
    if (serve_now) begin
      full_nxt[sel_now] = 1'b0;
    end
  end

  // bank of the incoming beat: high address bits reduced msb first by
  // compare and subtract, then the hart added and reduced once more
  always_comb begin
    hi_bits = HI_W'(in_item.ent.address >> (LOG_BANK_WORDS + 2));
    rem_acc = '0;
    rem_t   = '0;
    for (int i = HI_W - 1; i >= 0; i--) begin
      rem_t   = {rem_acc, hi_bits[i]};
      rem_acc = (rem_t >= (HW+1)'(NUM_HARTS)) ? HW'(rem_t - (HW+1)'(NUM_HARTS))
                                             : HW'(rem_t);
    end
    bank_t   = {1'b0, rem_acc} + {1'b0, hart_red};
    bank_now = (bank_t >= (HW+1)'(NUM_HARTS)) ? HW'(bank_t - (HW+1)'(NUM_HARTS))
                                             : HW'(bank_t);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r  <= '0;
      serve_r <= 1'b0;
    end else if (cmd.capture) begin
      full_r  <= full_nxt;
      serve_r <= serve_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sel_r <= sel_now;
      if (in_item.in_valid) begin
        entries_r[hart_red] <= in_item.ent;
        bank_r[hart_red]    <= bank_now;
      end
    end
    if (cmd.exec) begin
      out_r <= out_nxt;
    end
  end

  // served entry and its word address
  assign cur      = entries_r[sel_r];
  assign mem_addr = {bank_r[sel_r], LOG_BANK_WORDS'(cur.address >> 2)};

  always_comb begin
    case (cur.address[1:0])
      2'd0:    ld_byte = mem_rdata[7:0];
      2'd1:    ld_byte = mem_rdata[15:8];
      2'd2:    ld_byte = mem_rdata[23:16];
      2'd3:    ld_byte = mem_rdata[31:24];
      default: ld_byte = mem_rdata[7:0];
    endcase
    ld_half = cur.address[1] ? mem_rdata[31:16] : mem_rdata[15:0];
    case (cur.width_code)
      F3_LB:   ld_val = {{24{ld_byte[7]}}, ld_byte};
      F3_LH:   ld_val = {{16{ld_half[15]}}, ld_half};
      F3_LBU:  ld_val = {24'd0, ld_byte};
      F3_LHU:  ld_val = {16'd0, ld_half};
      default: ld_val = mem_rdata;
    endcase
  end

  // store merge by byte enables
  always_comb begin
    case (cur.width_code[1:0])
      SZ_BYTE: begin
        st_be    = 4'b0001 << cur.address[1:0];
        st_lanes = {4{cur.value[7:0]}};
      end
      SZ_HALF: begin
        st_be    = cur.address[1] ? 4'b1100 : 4'b0011;
        st_lanes = {2{cur.value[15:0]}};
      end
      SZ_WORD: begin
        st_be    = 4'b1111;
        st_lanes = cur.value;
      end
      default: begin
        st_be    = 4'b0000;
        st_lanes = cur.value;
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      mem_wdata[8*i +: 8] = st_be[i] ? st_lanes[8*i +: 8] : mem_rdata[8*i +: 8];
    end
    mem_we = cmd.exec && serve_r && !cur.is_load && cur.is_write && (st_be != 4'b0000);
  end

  mas_ram #(
    .WIDTH (32),
    .DEPTH (1 << AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign full8 = 8'(full_r);

  always_comb begin
    out_nxt                = '0;
    out_nxt.out_valid      = serve_r;
    out_nxt.slot_full_mask = full8[3:0];
    if (serve_r) begin
      out_nxt.hart    = 2'(sel_r);
      out_nxt.rd      = cur.rd;
      out_nxt.no_dest = cur.no_dest;
      out_nxt.is_ret  = cur.is_ret;
      out_nxt.value   = cur.is_load ? ld_val : cur.value;
    end
  end

  assign out_item     = out_r;
  assign status.serve = serve_now;
endmodule

// ----- rtl/multihart_memory_access_stage.sv -----
// memory stage of an interleaved multithreaded pipeline, one slot per hart
// sequence: accept, then a ram read state when a hart is served, then execute;
//   execute follows accept directly when nothing is served
// one beat at a time: no new input beat is accepted until the result beat is
//   taken; the ram read is registered and a store is a read-modify-write
// reset: synchronous, clears slot-full flags and the sequencer; ram and slots undefined
module multihart_memory_access_stage #(
  parameter int NUM_HARTS      = 4,
  parameter int LOG_BANK_WORDS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  mas_in_if.sink    in_ch,
  mas_out_if.source out_ch
);
  import mas_pkg::*;

  cmd_t      cmd;
  status_t   status;
  in_item_t  in_item;
  out_item_t out_item;

  // gather the input beat into one item
  always_comb begin
    in_item                = '0;
    in_item.in_valid       = in_ch.in_valid;
    in_item.hart           = in_ch.in_hart;
    in_item.ent.rd         = in_ch.in_rd;
    in_item.ent.no_dest    = in_ch.in_no_dest;
    in_item.ent.is_load    = in_ch.in_is_load;
    in_item.ent.is_write   = in_ch.in_is_write;
    in_item.ent.width_code = in_ch.in_width_code;
    in_item.ent.is_ret     = in_ch.in_is_ret;
    in_item.ent.address    = in_ch.in_address;
    in_item.ent.value      = in_ch.in_value;
    in_item.wb_full_mask   = in_ch.wb_full_mask;
  end

  // sequencer: accept, ram read when a hart is served, execute, result beat
  mas_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_beat_valid  (in_ch.valid),
    .in_beat_ready  (in_ch.ready),
    .out_beat_valid (out_ch.valid),
    .out_beat_ready (out_ch.ready),
    .cmd            (cmd),
    .status         (status)
  );

  // slots, pick logic, bank computation and the banked data memory
  mas_dp #(
    .NUM_HARTS      (NUM_HARTS),
    .LOG_BANK_WORDS (LOG_BANK_WORDS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_item  (in_item),
    .out_item (out_item)
  );

  // result beat fields, held in the datapath output register until taken
  assign out_ch.out_valid      = out_item.out_valid;
  assign out_ch.out_hart       = out_item.hart;
  assign out_ch.out_rd         = out_item.rd;
  assign out_ch.out_no_dest    = out_item.no_dest;
  assign out_ch.out_is_ret     = out_item.is_ret;
  assign out_ch.out_value      = out_item.value;
  assign out_ch.slot_full_mask = out_item.slot_full_mask;
endmodule
